[rtl/core/dssa_pkg.sv]
// ----------------------------------------------------------------------------
// dssa_pkg
// constants and codes shared by the two-stacks-in-one-array core
// ----------------------------------------------------------------------------
package dssa_pkg;

    localparam int DEPTH   = 16;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_ONE = 3'd0;
    localparam logic [2:0] CMD_POP_ONE  = 3'd1;
    localparam logic [2:0] CMD_DUMP_ONE = 3'd2;
    localparam logic [2:0] CMD_PUSH_TWO = 3'd3;
    localparam logic [2:0] CMD_POP_TWO  = 3'd4;
    localparam logic [2:0] CMD_DUMP_TWO = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    // memory port controls
    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [AW-1:0]     raddr;
    } t_ram_ctrl;

endpackage

[rtl/core/dssa_ram.sv]
// ----------------------------------------------------------------------------
// dssa_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dssa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/dual_stack_shared_array_core.sv]
// ----------------------------------------------------------------------------
// dual_stack_shared_array_core
// two stacks in one shared memory: stack one grows up, stack two grows down
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in       input      i_in_valid / o_in_ready    i_command, i_push_value
//  out      output     o_out_valid / i_out_ready  o_status, o_data_word, o_last
//
//  push, overflow, underflow and empty dump: result registered in the cycle after
//  the transaction; the next command is taken as that result is sent, unless out is stalled.
//  pop: the memory read, then the registered result; no command is taken in between.
//  dump of n entries: n reads, one read per cycle while out is not stalled.
//  a stall on out holds the pending read data and the dump position.
//  synchronous active-low reset empties both stacks; memory contents are kept.
// ----------------------------------------------------------------------------
module dual_stack_shared_array_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_push_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_data_word,
    output logic               o_last
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WAIT = 2'b10
    } t_state;

    localparam logic [dssa_pkg::CW-1:0] TOP_IDX = dssa_pkg::CW'(dssa_pkg::DEPTH - 1);
    localparam logic [dssa_pkg::CW:0]   FULL    = (dssa_pkg::CW + 1)'(dssa_pkg::DEPTH);

    t_state                     r_state, n_state;
    logic [dssa_pkg::CW-1:0]    r_low, n_low;
    logic [dssa_pkg::CW-1:0]    r_high, n_high;
    logic [dssa_pkg::CW-1:0]    r_idx, n_idx;
    logic [dssa_pkg::CW-1:0]    r_total, n_total;
    logic                       r_side, n_side;
    logic                       r_wlast, n_wlast;
    logic                       r_out_valid, n_out_valid;
    logic [1:0]                 r_status, n_status;
    logic [31:0]                r_data, n_data;
    logic                       r_last, n_last;

    dssa_pkg::t_ram_ctrl        ram;
    logic [dssa_pkg::DATA_W-1:0] rdata;

    logic                       slot_free;
    logic                       accept;
    logic [dssa_pkg::CW:0]      used;
    logic [dssa_pkg::CW-1:0]    high_top;
    logic [dssa_pkg::CW-1:0]    high_pop;
    logic [dssa_pkg::CW-1:0]    dump_addr;

    dssa_ram #(
        .DEPTH (dssa_pkg::DEPTH),
        .WIDTH (dssa_pkg::DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram.we),
        .i_waddr (ram.waddr),
        .i_wdata (ram.wdata),
        .i_re    (ram.re),
        .i_raddr (ram.raddr),
        .o_rdata (rdata)
    );

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign used       = {1'b0, r_low} + {1'b0, r_high};
    // next free word of stack two, and its current top
    assign high_top   = TOP_IDX - r_high;
    assign high_pop   = high_top + dssa_pkg::CW'(1);
    // next dump word for the stack being sent
    assign dump_addr  = r_side ? (TOP_IDX - r_idx) : r_idx;

    always_comb begin
        n_state     = r_state;
        n_low       = r_low;
        n_high      = r_high;
        n_idx       = r_idx;
        n_total     = r_total;
        n_side      = r_side;
        n_wlast     = r_wlast;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_data      = r_data;
        n_last      = r_last;
        ram.we      = 1'b0;
        ram.waddr   = r_low[dssa_pkg::AW-1:0];
        ram.wdata   = i_push_value;
        ram.re      = 1'b0;
        ram.raddr   = dump_addr[dssa_pkg::AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_command)
                        dssa_pkg::CMD_PUSH_ONE, dssa_pkg::CMD_PUSH_TWO: begin
                            n_out_valid = 1'b1;
                            n_data      = '0;
                            n_last      = 1'b1;
                            if (used >= FULL) begin
                                n_status = dssa_pkg::ST_OVERFLOW;
                            end else begin
                                n_status = dssa_pkg::ST_OK;
                                ram.we   = 1'b1;
                                if (i_command == dssa_pkg::CMD_PUSH_ONE) begin
                                    ram.waddr = r_low[dssa_pkg::AW-1:0];
                                    n_low     = r_low + dssa_pkg::CW'(1);
                                end else begin
                                    ram.waddr = high_top[dssa_pkg::AW-1:0];
                                    n_high    = r_high + dssa_pkg::CW'(1);
                                end
                            end
                        end
                        dssa_pkg::CMD_POP_ONE, dssa_pkg::CMD_POP_TWO: begin
                            if ((i_command == dssa_pkg::CMD_POP_ONE) ? (r_low == '0)
                                                                     : (r_high == '0)) begin
                                n_out_valid = 1'b1;
                                n_status    = dssa_pkg::ST_UNDERFLOW;
                                n_data      = '0;
                                n_last      = 1'b1;
                            end else begin
                                ram.re  = 1'b1;
                                n_wlast = 1'b1;
                                n_state = S_WAIT;
                                if (i_command == dssa_pkg::CMD_POP_ONE) begin
                                    n_low     = r_low - dssa_pkg::CW'(1);
                                    ram.raddr = n_low[dssa_pkg::AW-1:0];
                                end else begin
                                    ram.raddr = high_pop[dssa_pkg::AW-1:0];
                                    n_high    = r_high - dssa_pkg::CW'(1);
                                end
                            end
                        end
                        dssa_pkg::CMD_DUMP_ONE, dssa_pkg::CMD_DUMP_TWO: begin
                            n_side  = (i_command == dssa_pkg::CMD_DUMP_TWO);
                            n_total = n_side ? r_high : r_low;
                            if (n_total == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = dssa_pkg::ST_EMPTY;
                                n_data      = '0;
                                n_last      = 1'b1;
                            end else begin
                                ram.re    = 1'b1;
                                ram.raddr = n_side ? TOP_IDX[dssa_pkg::AW-1:0] : '0;
                                n_idx     = dssa_pkg::CW'(1);
                                n_wlast   = (n_total == dssa_pkg::CW'(1));
                                n_state   = S_WAIT;
                            end
                        end
                        default: begin
                            // undefined command: dropped without a result
                        end
                    endcase
                end
            end
            S_WAIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_status    = dssa_pkg::ST_OK;
                    n_data      = rdata;
                    n_last      = r_wlast;
                    if (r_wlast) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch the next dump word while this one goes out
                        ram.re  = 1'b1;
                        n_idx   = r_idx + dssa_pkg::CW'(1);
                        n_wlast = (n_idx == r_total);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low       <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_high      <= n_high;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_total  <= n_total;
        r_side   <= n_side;
        r_wlast  <= n_wlast;
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data_word = r_data;
    assign o_last      = r_last;

endmodule

[tb/dual_stack_shared_array_core_test.sv]
// ----------------------------------------------------------------------------
// dual_stack_shared_array_core_test
// self-checking bench for the two-stacks-in-one-array core: random push, pop
// and dump traffic on both stacks with stalls on both channels, every
// result compared against a behavioral copy of the two stacks
// ----------------------------------------------------------------------------
module dual_stack_shared_array_core_test;

    // codes the block must ignore
    localparam logic [2:0] CMD_RESERVED_6 = 3'd6;
    localparam logic [2:0] CMD_RESERVED_7 = 3'd7;

    localparam int RANDOM_COMMANDS = 240;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 30;

    typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} t_phase;

    typedef struct packed {
        logic [1:0]                  status;
        logic [dssa_pkg::DATA_W-1:0] word;
        logic                        last;
    } t_stack_result;

    class t_stack_scoreboard;
        logic [dssa_pkg::DATA_W-1:0] words [dssa_pkg::DEPTH];
        int unsigned                 low_used;
        int unsigned                 high_used;
        t_stack_result               expected_q[$];
        int                          errors;

        function void clear_stacks();
            low_used  = 0;
            high_used = 0;
            errors    = 0;
            expected_q.delete();
        endfunction

        function void push_expected(logic [1:0] status, logic [dssa_pkg::DATA_W-1:0] word,
                                    logic last);
            t_stack_result r;
            r.status = status;
            r.word   = word;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        // predict every result caused by one accepted command
        function void note_command(logic [2:0] cmd, logic [dssa_pkg::DATA_W-1:0] value);
            case (cmd)
                dssa_pkg::CMD_PUSH_ONE, dssa_pkg::CMD_PUSH_TWO: begin
                    if (low_used + high_used >= dssa_pkg::DEPTH) begin
                        push_expected(dssa_pkg::ST_OVERFLOW, '0, 1'b1);
                    end else begin
                        if (cmd == dssa_pkg::CMD_PUSH_ONE) begin
                            words[low_used] = value;
                            low_used++;
                        end else begin
                            high_used++;
                            words[dssa_pkg::DEPTH - high_used] = value;
                        end
                        push_expected(dssa_pkg::ST_OK, '0, 1'b1);
                    end
                end
                dssa_pkg::CMD_POP_ONE: begin
                    if (low_used == 0) begin
                        push_expected(dssa_pkg::ST_UNDERFLOW, '0, 1'b1);
                    end else begin
                        low_used--;
                        push_expected(dssa_pkg::ST_OK, words[low_used], 1'b1);
                    end
                end
                dssa_pkg::CMD_POP_TWO: begin
                    if (high_used == 0) begin
                        push_expected(dssa_pkg::ST_UNDERFLOW, '0, 1'b1);
                    end else begin
                        push_expected(dssa_pkg::ST_OK, words[dssa_pkg::DEPTH - high_used],
                                      1'b1);
                        high_used--;
                    end
                end
                dssa_pkg::CMD_DUMP_ONE: begin
                    if (low_used == 0) begin
                        push_expected(dssa_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < low_used; i++)
                            push_expected(dssa_pkg::ST_OK, words[i], i + 1 == low_used);
                    end
                end
                dssa_pkg::CMD_DUMP_TWO: begin
                    if (high_used == 0) begin
                        push_expected(dssa_pkg::ST_EMPTY, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < high_used; i++)
                            push_expected(dssa_pkg::ST_OK, words[dssa_pkg::DEPTH - 1 - i],
                                          i + 1 == high_used);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [1:0] status, logic [dssa_pkg::DATA_W-1:0] word,
                                   logic last);
            t_stack_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result with nothing expected: status %0d data_word %h last %0d",
                       status, word, last);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, status);
                errors++;
            end
            if (word !== exp_r.word) begin
                $error("data_word: expected %h, actual %h", exp_r.word, word);
                errors++;
            end
            if (last !== exp_r.last) begin
                $error("last: expected %0d, actual %0d", exp_r.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [2:0]         i_command;
    logic signed [31:0] i_push_value;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_status;
    logic signed [31:0] o_data_word;
    logic               o_last;

    t_stack_scoreboard stacks_sb;
    int                results_seen;
    bit                burst_mode;

    dual_stack_shared_array_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_data_word  (o_data_word),
        .o_last       (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // called just after a falling edge; returns just after the one that follows acceptance
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] value);
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_push_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        stacks_sb.note_command(cmd, value);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // hold the input off until every outstanding result has been received
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (stacks_sb.pending() != 0);
    endtask

    function automatic int sender_gap();
        int r;
        r = $urandom_range(99);
        if (burst_mode || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(30, 8);
    endfunction

    function automatic logic [2:0] pick_command(t_phase phase);
        int r;
        int push_w;
        int pop_w;
        r = $urandom_range(99);
        case (phase)
            PHASE_FILL:  begin push_w = 75; pop_w = 10; end
            PHASE_DRAIN: begin push_w = 10; pop_w = 75; end
            default:     begin push_w = 40; pop_w = 40; end
        endcase
        if (r < 3)
            return $urandom_range(1) ? CMD_RESERVED_6 : CMD_RESERVED_7;
        else if (r < 3 + push_w)
            return $urandom_range(1) ? dssa_pkg::CMD_PUSH_ONE : dssa_pkg::CMD_PUSH_TWO;
        else if (r < 3 + push_w + pop_w)
            return $urandom_range(1) ? dssa_pkg::CMD_POP_ONE : dssa_pkg::CMD_POP_TWO;
        else
            return $urandom_range(1) ? dssa_pkg::CMD_DUMP_ONE : dssa_pkg::CMD_DUMP_TWO;
    endfunction

    // result side: random back-pressure plus one long hold while traffic continues
    initial begin
        int  stall_left;
        int  eager_left;
        int  r;
        bit  long_hold_done;
        stall_left     = 0;
        eager_left     = 0;
        long_hold_done = 0;
        results_seen   = 0;
        i_out_ready    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                stacks_sb.check_result(o_status, o_data_word, o_last);
                results_seen++;
            end
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!long_hold_done && results_seen >= 60) begin
                long_hold_done = 1;
                stall_left     = LONG_HOLD_CYCLES - 1;
                i_out_ready    <= 1'b0;
            end else if (eager_left > 0) begin
                eager_left--;
                i_out_ready <= 1'b1;
            end else begin
                r = $urandom_range(99);
                if (r < 60) begin
                    i_out_ready <= 1'b1;
                end else if (r < 85) begin
                    stall_left  = $urandom_range(2);
                    i_out_ready <= 1'b0;
                end else if (r < 95) begin
                    eager_left  = $urandom_range(80, 20);
                    i_out_ready <= 1'b1;
                end else begin
                    stall_left  = $urandom_range(40, 8);
                    i_out_ready <= 1'b0;
                end
            end
        end
    end

    initial begin
        int          counted;
        int          phase_len;
        t_phase      phase;
        logic [2:0]  cmd;
        stacks_sb = new();
        stacks_sb.clear_stacks();
        burst_mode   = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = dssa_pkg::CMD_PUSH_ONE;
        i_push_value = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty-stack cases, extreme words, ignored codes
        send_command(dssa_pkg::CMD_POP_ONE, 32'h0);
        send_command(dssa_pkg::CMD_POP_TWO, 32'hFFFF_FFFF);
        send_command(dssa_pkg::CMD_DUMP_ONE, 32'h0);
        send_command(dssa_pkg::CMD_DUMP_TWO, 32'h0);
        send_command(dssa_pkg::CMD_PUSH_ONE, 32'h7FFF_FFFF);
        send_command(dssa_pkg::CMD_PUSH_ONE, 32'h8000_0000);
        send_command(dssa_pkg::CMD_PUSH_TWO, 32'hFFFF_FFFF);
        idle_sender(3);
        send_command(dssa_pkg::CMD_PUSH_TWO, 32'h0000_0000);
        send_command(dssa_pkg::CMD_PUSH_ONE, 32'h0000_0001);
        send_command(dssa_pkg::CMD_DUMP_ONE, 32'h0);
        send_command(dssa_pkg::CMD_DUMP_TWO, 32'h0);
        send_command(CMD_RESERVED_6, 32'h1234_5678);
        send_command(dssa_pkg::CMD_POP_TWO, 32'h0);
        send_command(CMD_RESERVED_7, 32'h0);
        send_command(dssa_pkg::CMD_POP_ONE, 32'h0);
        send_command(dssa_pkg::CMD_POP_ONE, 32'h0);
        send_command(dssa_pkg::CMD_POP_ONE, 32'h0);
        send_command(dssa_pkg::CMD_POP_ONE, 32'h0);
        send_command(dssa_pkg::CMD_POP_TWO, 32'h0);
        send_command(dssa_pkg::CMD_POP_TWO, 32'h0);
        send_command(dssa_pkg::CMD_DUMP_ONE, 32'h0);
        wait_for_results();

        // random phases; the first one fills the store to force overflows
        counted = 0;
        phase   = PHASE_FILL;
        phase_len = 30;
        while (counted < RANDOM_COMMANDS) begin
            burst_mode = ($urandom_range(3) == 0);
            for (int n = 0; n < phase_len && counted < RANDOM_COMMANDS; n++) begin
                cmd = pick_command(phase);
                if (cmd != CMD_RESERVED_6 && cmd != CMD_RESERVED_7)
                    counted++;
                send_command(cmd, $urandom);
                idle_sender(sender_gap());
            end
            if ($urandom_range(2) == 0)
                wait_for_results();
            case ($urandom_range(2))
                0:       phase = PHASE_FILL;
                1:       phase = PHASE_DRAIN;
                default: phase = PHASE_MIXED;
            endcase
            phase_len = $urandom_range(40, 10);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (stacks_sb.errors == 0 && stacks_sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
